>>> src/skt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sorted key table.
package skt_pkg;

   localparam int DEF_TABLE_DEPTH = 16;
   localparam int KIND_W          = 2;
   localparam int ID_W            = 8;
   localparam int KEY_W           = 16;
   localparam int STATUS_W        = 2;
   localparam int POS_W           = 4;
   localparam int FILL_W          = 5;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_LOOKUP = 2'd2
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_MISSING = 2'd2,
      ST_PRESENT = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_SHIFT,
      S_WRITE_NEW,
      S_RESPOND
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [KEY_W-1:0] key;
   } entry_type;

   typedef struct packed {
      logic id_hit;
      logic key_le;
   } cmp_res_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

>>> src/skt_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered read.
module skt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/skt_cmp.sv
`timescale 1ns / 1ps
// Shared compare unit: identifier match and key ordering against one entry.
module skt_cmp (
   input  logic [skt_pkg::ID_W-1:0]  cur_id,
   input  logic [skt_pkg::KEY_W-1:0] cur_key,
   input  skt_pkg::entry_type        entry,
   output skt_pkg::cmp_res_type      cmp_res
);

   import skt_pkg::*;

   always_comb begin
      cmp_res.id_hit = (entry.id == cur_id);
      cmp_res.key_le = (cur_key <= entry.key);
   end

endmodule

>>> src/skt_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for scan, shift and insert over the entry RAM.
module skt_ctrl #(
   parameter int TABLE_DEPTH = skt_pkg::DEF_TABLE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [skt_pkg::KIND_W-1:0]          req_kind,
   input  logic [skt_pkg::ID_W-1:0]            req_app_id,
   input  logic [skt_pkg::KEY_W-1:0]           req_app_size,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [skt_pkg::STATUS_W-1:0]        rsp_status,
   output logic [skt_pkg::POS_W-1:0]           rsp_position,
   output logic [skt_pkg::FILL_W-1:0]          rsp_fill_count,
   output logic                                ram_wr_en,
   output logic [$clog2(TABLE_DEPTH)-1:0]      ram_wr_addr,
   output skt_pkg::entry_type                  ram_wr_data,
   output logic                                ram_rd_en,
   output logic [$clog2(TABLE_DEPTH)-1:0]      ram_rd_addr,
   input  skt_pkg::entry_type                  ram_rd_data,
   output logic [skt_pkg::ID_W-1:0]            cur_id,
   output logic [skt_pkg::KEY_W-1:0]           cur_key,
   input  skt_pkg::cmp_res_type                cmp_res
);

   import skt_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [KIND_W-1:0]     kind_ff, kind_in;
   logic [ID_W-1:0]       id_ff, id_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [CNT_W-1:0]      ptr_ff, ptr_in;
   logic [CNT_W-1:0]      left_ff, left_in;
   logic                  dir_up_ff, dir_up_in;
   logic [IDX_W-1:0]      rd_idx_ff, rd_idx_in;
   logic                  found_ff, found_in;
   logic [IDX_W-1:0]      found_idx_ff, found_idx_in;
   logic                  pos_hit_ff, pos_hit_in;
   logic [CNT_W-1:0]      ins_pos_ff, ins_pos_in;
   status_type            status_ff, status_in;
   logic [IDX_W-1:0]      pos_ff, pos_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]      rsp_position_ff, rsp_position_in;
   logic [FILL_W-1:0]     rsp_fill_ff, rsp_fill_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff         <= kind_in;
      id_ff           <= id_in;
      key_ff          <= key_in;
      ptr_ff          <= ptr_in;
      left_ff         <= left_in;
      dir_up_ff       <= dir_up_in;
      rd_idx_ff       <= rd_idx_in;
      found_ff        <= found_in;
      found_idx_ff    <= found_idx_in;
      pos_hit_ff      <= pos_hit_in;
      ins_pos_ff      <= ins_pos_in;
      status_ff       <= status_in;
      pos_ff          <= pos_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_position_ff <= rsp_position_in;
      rsp_fill_ff     <= rsp_fill_in;
   end

   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      rsp_valid_in    = rsp_valid_ff;
      kind_in         = kind_ff;
      id_in           = id_ff;
      key_in          = key_ff;
      ptr_in          = ptr_ff;
      left_in         = left_ff;
      dir_up_in       = dir_up_ff;
      found_in        = found_ff;
      found_idx_in    = found_idx_ff;
      pos_hit_in      = pos_hit_ff;
      ins_pos_in      = ins_pos_ff;
      status_in       = status_ff;
      pos_in          = pos_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_position_in = rsp_position_ff;
      rsp_fill_in     = rsp_fill_ff;

      req_ready   = 1'b0;
      ram_rd_en   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = rd_idx_ff;
      ram_wr_data = ram_rd_data;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in    = req_kind;
               id_in      = req_app_id;
               key_in     = req_app_size;
               ptr_in     = '0;
               left_in    = cnt_ff;
               dir_up_in  = 1'b1;
               found_in   = 1'b0;
               pos_hit_in = 1'b0;
               ins_pos_in = cnt_ff;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            if (left_ff != '0) begin
               ram_rd_en = 1'b1;
               ptr_in    = ptr_ff + CNT_W'(1);
               left_in   = left_ff - CNT_W'(1);
            end
            if (rd_vld_ff) begin
               if (!found_ff && cmp_res.id_hit) begin
                  found_in     = 1'b1;
                  found_idx_in = rd_idx_ff;
               end
               if (!pos_hit_ff && cmp_res.key_le) begin
                  pos_hit_in = 1'b1;
                  ins_pos_in = CNT_W'(rd_idx_ff);
               end
            end
            if (left_ff == '0 && !rd_vld_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            pos_in   = '0;
            state_in = S_RESPOND;
            case (kind_ff)
               KIND_INSERT: begin
                  if (found_ff) begin
                     status_in = ST_PRESENT;
                  end else if (cnt_ff == FULL_CNT) begin
                     status_in = ST_FULL;
                  end else begin
                     status_in = ST_OK;
                     pos_in    = ins_pos_ff[IDX_W-1:0];
                     ptr_in    = cnt_ff - CNT_W'(1);
                     left_in   = cnt_ff - ins_pos_ff;
                     dir_up_in = 1'b0;
                     state_in  = S_SHIFT;
                  end
               end
               KIND_REMOVE: begin
                  if (!found_ff) begin
                     status_in = ST_MISSING;
                  end else begin
                     status_in = ST_OK;
                     pos_in    = found_idx_ff;
                     ptr_in    = CNT_W'(found_idx_ff) + CNT_W'(1);
                     left_in   = cnt_ff - CNT_W'(found_idx_ff) - CNT_W'(1);
                     dir_up_in = 1'b1;
                     state_in  = S_SHIFT;
                  end
               end
               default: begin
                  if (!found_ff) begin
                     status_in = ST_MISSING;
                  end else begin
                     status_in = ST_OK;
                     pos_in    = found_idx_ff;
                  end
               end
            endcase
         end
         S_SHIFT: begin
            if (left_ff != '0) begin
               ram_rd_en = 1'b1;
               ptr_in    = dir_up_ff ? ptr_ff + CNT_W'(1) : ptr_ff - CNT_W'(1);
               left_in   = left_ff - CNT_W'(1);
            end
            if (rd_vld_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = dir_up_ff ? rd_idx_ff - IDX_W'(1) : rd_idx_ff + IDX_W'(1);
            end
            if (left_ff == '0 && !rd_vld_ff) begin
               if (kind_ff == KIND_INSERT) begin
                  state_in = S_WRITE_NEW;
               end else begin
                  cnt_in   = cnt_ff - CNT_W'(1);
                  state_in = S_RESPOND;
               end
            end
         end
         S_WRITE_NEW: begin
            ram_wr_en       = 1'b1;
            ram_wr_addr     = pos_ff;
            ram_wr_data.id  = id_ff;
            ram_wr_data.key = key_ff;
            cnt_in          = cnt_ff + CNT_W'(1);
            state_in        = S_RESPOND;
         end
         S_RESPOND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = status_ff;
               rsp_position_in = (status_ff == ST_OK) ? POS_W'(pos_ff) : '0;
               rsp_fill_in     = FILL_W'(cnt_ff);
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rd_vld_in = ram_rd_en;
      rd_idx_in = ptr_ff[IDX_W-1:0];
   end

   assign ram_rd_addr    = ptr_ff[IDX_W-1:0];
   assign cur_id         = id_ff;
   assign cur_key        = key_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_position   = rsp_position_ff;
   assign rsp_fill_count = rsp_fill_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FULL_CNT)
      else $error("fill count above table depth");

   a_wr_state: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == S_SHIFT || state_ff == S_WRITE_NEW))
      else $error("table write outside shift or insert");

   a_err_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> (rsp_position_ff == '0))
      else $error("error result with nonzero position");

   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_SCAN))
      else $error("accepted item did not start a scan");

   a_insert_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE_NEW) |=> (cnt_ff == $past(cnt_ff) + CNT_W'(1)))
      else $error("insert did not grow the table");

endmodule

>>> src/sorted_key_table_unit.sv
`timescale 1ns / 1ps
// Sorted key table: entries kept in ascending key order, with insert, remove
// and lookup by identifier.
//
// Input channel req_*: one item per request (kind, identifier, key). Result
// channel rsp_*: exactly one item per request (status, position, fill count).
// Both use valid/ready; an item moves when valid and ready are high together.
//
// Each request first scans the valid entries through the entry RAM, one read
// per cycle, then for an insert or remove shifts the later entries one place,
// again one RAM read and one write per cycle. The next request can be accepted
// from the cycle in which rsp_valid rises. The entry RAM has a single read
// port. One request is in work at a time.
//
// Reset empties the table (fill count zero); entry contents need no clearing.
// A result waits in the output register while rsp_ready is low; the next
// request may be accepted meanwhile, but its result waits behind it.
module sorted_key_table_unit #(
   parameter int TABLE_DEPTH = skt_pkg::DEF_TABLE_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [skt_pkg::KIND_W-1:0]   req_kind,
   input  logic [skt_pkg::ID_W-1:0]     req_app_id,
   input  logic [skt_pkg::KEY_W-1:0]    req_app_size,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [skt_pkg::STATUS_W-1:0] rsp_status,
   output logic [skt_pkg::POS_W-1:0]    rsp_position,
   output logic [skt_pkg::FILL_W-1:0]   rsp_fill_count
);

   import skt_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   entry_type        ram_wr_data;
   logic             ram_rd_en;
   logic [IDX_W-1:0] ram_rd_addr;
   entry_type        ram_rd_data;
   logic [ENTRY_W-1:0] ram_rd_bits;
   logic [ID_W-1:0]  cur_id;
   logic [KEY_W-1:0] cur_key;
   cmp_res_type      cmp_res;

   assign ram_rd_data = entry_type'(ram_rd_bits);

   skt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_bits)
   );

   skt_cmp u_cmp (
      .cur_id  (cur_id),
      .cur_key (cur_key),
      .entry   (ram_rd_data),
      .cmp_res (cmp_res)
   );

   skt_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_app_id     (req_app_id),
      .req_app_size   (req_app_size),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_position   (rsp_position),
      .rsp_fill_count (rsp_fill_count),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_wr_data    (ram_wr_data),
      .ram_rd_en      (ram_rd_en),
      .ram_rd_addr    (ram_rd_addr),
      .ram_rd_data    (ram_rd_data),
      .cur_id         (cur_id),
      .cur_key        (cur_key),
      .cmp_res        (cmp_res)
   );

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench for sorted_key_table_unit: directed and random requests checked by a scoreboard.
module tb_top;
   import skt_pkg::*;

   localparam int DEPTH       = skt_pkg::DEF_TABLE_DEPTH;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 78;
   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    position;
      logic [FILL_W-1:0]   fill_count;
   } table_result_type;

   class sorted_table_tracker;
      logic [KEY_W-1:0] keys[DEPTH];
      logic [ID_W-1:0]  ids[DEPTH];
      int               used = 0;
      int               faults = 0;
      table_result_type pending_results[$];

      function void note_request(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                                 logic [KEY_W-1:0] size);
         int               hit;
         int               slot;
         int               i;
         table_result_type r;
         hit = -1;
         for (i = 0; i < used; i++)
            if (hit < 0 && ids[i] == id) hit = i;
         r.status   = ST_OK;
         r.position = '0;
         case (kind)
            KIND_INSERT: begin
               if (hit >= 0) begin
                  r.status = ST_PRESENT;
               end else if (used >= DEPTH) begin
                  r.status = ST_FULL;
               end else begin
                  slot = 0;
                  while (slot < used && size > keys[slot]) slot++;
                  for (i = used; i > slot; i--) begin
                     keys[i] = keys[i-1];
                     ids[i]  = ids[i-1];
                  end
                  keys[slot] = size;
                  ids[slot]  = id;
                  used++;
                  r.position = POS_W'(slot);
               end
            end
            KIND_REMOVE: begin
               if (hit < 0) begin
                  r.status = ST_MISSING;
               end else begin
                  for (i = hit; i + 1 < used; i++) begin
                     keys[i] = keys[i+1];
                     ids[i]  = ids[i+1];
                  end
                  used--;
                  r.position = POS_W'(hit);
               end
            end
            default: begin
               if (hit < 0) r.status = ST_MISSING;
               else r.position = POS_W'(hit);
            end
         endcase
         r.fill_count = FILL_W'(used);
         pending_results.push_back(r);
      endfunction

      function void check_result(logic [STATUS_W-1:0] status, logic [POS_W-1:0] position,
                                 logic [FILL_W-1:0] fill_count);
         table_result_type want;
         if (pending_results.size() == 0) begin
            faults++;
            if (faults <= 10)
               $display("unexpected result: status %0d pos %0d fill %0d",
                        status, position, fill_count);
         end else begin
            want = pending_results.pop_front();
            if (want.status !== status || want.position !== position ||
                want.fill_count !== fill_count) begin
               faults++;
               if (faults <= 10)
                  $display("mismatch at %0t: status %0d/%0d pos %0d/%0d fill %0d/%0d (exp/act)",
                           $realtime, want.status, status, want.position, position,
                           want.fill_count, fill_count);
            end
         end
      endfunction

      function int outstanding();
         return pending_results.size();
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [KIND_W-1:0]   req_kind = '0;
   logic [ID_W-1:0]     req_app_id = '0;
   logic [KEY_W-1:0]    req_app_size = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [POS_W-1:0]    rsp_position;
   logic [FILL_W-1:0]   rsp_fill_count;

   sorted_table_tracker sb;
   int                  send_idle_pct = 20;
   int                  recv_idle_pct = 20;
   logic                hold_rsp = 1'b0;
   logic [ID_W-1:0]     id_pool[24];
   logic [KEY_W-1:0]    key_pool[4];

   always #1 clock = ~clock;

   sorted_key_table_unit #(.TABLE_DEPTH(DEPTH)) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_app_id     (req_app_id),
      .req_app_size   (req_app_size),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_position   (rsp_position),
      .rsp_fill_count (rsp_fill_count)
   );

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_request(req_kind, req_app_id, req_app_size);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_status, rsp_position, rsp_fill_count);
      end
   end

   // receiver: random stalls plus one long hold-off
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      int stale;
      stale = 0;
      while (stale < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) stale = 0;
         else stale++;
      end
      $display("tb_top NOT OK");
      $finish;
   end

   task automatic send_req(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                           input logic [KEY_W-1:0] size);
      if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_app_id   <= id;
      req_app_size <= size;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_random(input mix_type mix);
      int                roll;
      int                ins_pct;
      int                rem_pct;
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   id;
      logic [KEY_W-1:0]  size;
      case (mix)
         MIX_FILL:  begin ins_pct = 65; rem_pct = 15; end
         MIX_DRAIN: begin ins_pct = 15; rem_pct = 60; end
         default:   begin ins_pct = 40; rem_pct = 30; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < ins_pct) kind = KIND_INSERT;
      else if (roll < ins_pct + rem_pct) kind = KIND_REMOVE;
      else if (roll < 95) kind = KIND_LOOKUP;
      else kind = KIND_SPARE;
      if ($urandom_range(0, 99) < 80) id = id_pool[$urandom_range(0, 23)];
      else id = ID_W'($urandom_range(0, 255));
      roll = $urandom_range(0, 99);
      if (roll < 15) size = $urandom_range(0, 1) ? '1 : '0;
      else if (roll < 40) size = key_pool[$urandom_range(0, 3)];
      else size = KEY_W'($urandom_range(0, 65535));
      send_req(kind, id, size);
   endtask

   initial begin
      int      i;
      int      p;
      mix_type mix;
      sb = new;
      for (i = 0; i < 24; i++) id_pool[i] = ID_W'($urandom_range(0, 255));
      for (i = 0; i < 4; i++) key_pool[i] = KEY_W'($urandom_range(0, 65535));
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty table, extremes, equal keys, duplicates, spare kind
      send_req(KIND_LOOKUP, 8'h05, 16'h0000);
      send_req(KIND_INSERT, 8'h00, 16'h0000);
      send_req(KIND_INSERT, 8'hFF, 16'hFFFF);
      send_req(KIND_INSERT, 8'h80, 16'h8000);
      send_req(KIND_INSERT, 8'h7F, 16'h8000);
      send_req(KIND_INSERT, 8'h00, 16'h1234);
      send_req(KIND_LOOKUP, 8'hFF, 16'hAAAA);
      send_req(KIND_SPARE, 8'h80, 16'h5555);
      send_req(KIND_REMOVE, 8'h7F, 16'h0000);
      send_req(KIND_REMOVE, 8'h7F, 16'hFFFF);
      // fill to capacity, then overflow and duplicate-on-full
      for (i = 0; i < DEPTH - 3; i++)
         send_req(KIND_INSERT, ID_W'(8'h10 + i), KEY_W'(i * 16'h1357));
      send_req(KIND_INSERT, 8'h01, 16'h4000);
      send_req(KIND_INSERT, 8'hFF, 16'h0001);

      for (p = 0; p < PHASES; p++) begin
         mix = mix_type'(p % 3);
         case (p)
            1: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               hold_rsp      = 1'b1;
            end
            4, PHASES - 1: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
            default: begin
               send_idle_pct = $urandom_range(10, 40);
               recv_idle_pct = $urandom_range(10, 40);
            end
         endcase
         repeat (PHASE_ITEMS) send_random(mix);
      end
      req_valid <= 1'b0;

      while (sb.outstanding() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (sb.faults == 0 && sb.outstanding() == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
